@@ sv/p2p_pkg.sv @@
`default_nettype none

package p2p_pkg;

	localparam int MAX_NODES = 32;
	// index into the symbol stores, and a count that can hold MAX_NODES itself
	localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int CW = $clog2(MAX_NODES + 1);

	typedef struct packed {
		logic [7:0] pre_symbol;
		logic [7:0] in_symbol;
		logic       last_in;
	} item_t;

	typedef struct packed {
		logic [7:0] post_symbol;
		logic       last_out;
		logic       bad_input;
	} result_t;

	// subrange frame: of an emit frame only pre_at is used
	typedef struct packed {
		logic [IW-1:0] pre_at;
		logic [IW-1:0] in_at;
		logic [CW-1:0] len;
		logic          emit;
	} frame_t;

	localparam int FRAME_W = $bits(frame_t);

	typedef enum logic [7:0] {
		ST_LOAD   = 8'b0000_0001,
		ST_POP    = 8'b0000_0010,
		ST_FRAME  = 8'b0000_0100,
		ST_SYM    = 8'b0000_1000,
		ST_SCAN   = 8'b0001_0000,
		ST_PUSH_R = 8'b0010_0000,
		ST_PUSH_L = 8'b0100_0000,
		ST_OUT    = 8'b1000_0000
	} state_t;

endpackage

`default_nettype wire

@@ sv/p2p_ram.sv @@
`default_nettype none

module p2p_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                                          clk,
	input  wire logic                                          we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
	input  wire logic [WIDTH-1:0]                              wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
	output      logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ sv/preorder_inorder_to_postorder_top.sv @@
`default_nettype none

// Load: one position per cycle while busy is low; the last_in transfer starts the rebuild.
// Rebuild: an emit frame steps POP, FRAME, SYM; a subtree frame steps POP, FRAME, SYM,
//   SCAN (k inorder compares up to and including the root, one inorder RAM read per cycle),
//   PUSH_R and PUSH_L; the rebuild ends with one final pop.
// Output: N results, one per cycle, the first after the ST_OUT state and the post RAM read;
//   a missing root gives one error result the cycle after the failed scan. No stall input.
// Reset (arst_n low): FSM, counters and strobes clear at once; RAM contents are left as is.
module preorder_inorder_to_postorder_top (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output      logic             busy,
	input  wire p2p_pkg::item_t   item,
	output      logic             strobe,
	output      p2p_pkg::result_t result
);

	import p2p_pkg::*;

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	state_t        state_q;
	logic [CW-1:0] load_cnt_q;   // positions stored for the tree being loaded
	logic [CW-1:0] n_q;          // node count of the tree being rebuilt
	logic [CW-1:0] sp_q;         // frame stack pointer (entries in use)
	logic [CW-1:0] post_cnt_q;   // postorder symbols written so far
	logic [CW-1:0] i_q;          // scan offset into the inorder range
	logic [CW-1:0] o_q;          // output read pointer
	frame_t        f_q;          // frame being worked on
	logic [7:0]    root_q;       // root symbol searched for
	logic          rd_valid_s1;  // post RAM read data is a result
	logic          rd_last_s1;   // ... and it is the final one
	logic          err_q;        // one-cycle error result

	// ------------------------------------------------------------------
	// Memories: preorder, inorder, frame stack, postorder buffer.
	// Every access is sequenced by the FSM, so a write always lands on an earlier
	// edge than any read issued for the same entry; no forwarding is needed.
	// ------------------------------------------------------------------
	logic          pre_we, in_we, stk_we, post_we;
	logic [IW-1:0] ld_addr;
	logic [IW-1:0] pre_raddr, in_raddr, stk_waddr, stk_raddr, post_waddr, post_raddr;
	logic [7:0]    pre_rdata, in_rdata, post_rdata;
	frame_t        stk_wdata, stk_rdata;

	p2p_ram #(.WIDTH(8), .DEPTH(MAX_NODES)) u_pre_ram (
		.clk   (clk),
		.we    (pre_we),
		.waddr (ld_addr),
		.wdata (item.pre_symbol),
		.raddr (pre_raddr),
		.rdata (pre_rdata)
	);

	p2p_ram #(.WIDTH(8), .DEPTH(MAX_NODES)) u_in_ram (
		.clk   (clk),
		.we    (in_we),
		.waddr (ld_addr),
		.wdata (item.in_symbol),
		.raddr (in_raddr),
		.rdata (in_rdata)
	);

	p2p_ram #(.WIDTH(FRAME_W), .DEPTH(MAX_NODES)) u_stk_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	p2p_ram #(.WIDTH(8), .DEPTH(MAX_NODES)) u_post_ram (
		.clk   (clk),
		.we    (post_we),
		.waddr (post_waddr),
		.wdata (pre_rdata),
		.raddr (post_raddr),
		.rdata (post_rdata)
	);

	// ------------------------------------------------------------------
	// Datapath terms
	// ------------------------------------------------------------------
	logic          xfer;       // input transfer this cycle
	logic          room;       // store not yet full
	logic [CW-1:0] n_new;      // count including this transfer, if it fits
	logic          hit;        // scanned inorder symbol matches the root
	logic          scan_end;   // this compare is the last in range
	logic [CW-1:0] r_len;      // right subtree length
	logic [CW-1:0] i_next;

	assign busy     = (state_q != ST_LOAD);
	assign xfer     = start && !busy;
	assign room     = (load_cnt_q < CW'(MAX_NODES));
	assign n_new    = room ? (load_cnt_q + CW'(1)) : load_cnt_q;
	assign ld_addr  = load_cnt_q[IW-1:0];
	assign pre_we   = xfer && room;
	assign in_we    = xfer && room;

	assign hit      = (in_rdata == root_q);
	assign i_next   = i_q + CW'(1);
	assign scan_end = (i_next == f_q.len);
	assign r_len    = f_q.len - i_next;

	// root of a frame is the first preorder symbol of its range
	assign pre_raddr = stk_rdata.pre_at;
	assign stk_raddr = IW'(sp_q - CW'(1));
	assign stk_waddr = (state_q == ST_LOAD) ? '0 : sp_q[IW-1:0];

	// scan reads run one ahead of the compare
	always_comb begin
		if (state_q == ST_SCAN) begin
			in_raddr = IW'(CW'(f_q.in_at) + i_next);
		end else begin
			in_raddr = f_q.in_at;
		end
	end

	assign post_we    = (state_q == ST_SYM) && f_q.emit;
	assign post_waddr = post_cnt_q[IW-1:0];
	assign post_raddr = o_q[IW-1:0];

	// stack write port: root frame, then per subtree emit / right / left frames
	always_comb begin
		stk_we    = 1'b0;
		stk_wdata = f_q;
		unique case (state_q)
			ST_LOAD: begin
				stk_we    = xfer && item.last_in;
				stk_wdata = '{pre_at: '0, in_at: '0, len: n_new, emit: 1'b0};
			end
			ST_SCAN: begin
				stk_we    = hit;
				stk_wdata = '{pre_at: f_q.pre_at, in_at: f_q.in_at, len: CW'(1), emit: 1'b1};
			end
			ST_PUSH_R: begin
				stk_we    = (r_len != '0);
				stk_wdata = '{pre_at: IW'(CW'(f_q.pre_at) + i_next),
				              in_at:  IW'(CW'(f_q.in_at) + i_next),
				              len:    r_len,
				              emit:   1'b0};
			end
			ST_PUSH_L: begin
				stk_we    = (i_q != '0);
				stk_wdata = '{pre_at: IW'(CW'(f_q.pre_at) + CW'(1)),
				              in_at:  f_q.in_at,
				              len:    i_q,
				              emit:   1'b0};
			end
			ST_POP, ST_FRAME, ST_SYM, ST_OUT: begin
				stk_we    = 1'b0;
				stk_wdata = f_q;
			end
			default: begin
				stk_we    = 1'b0;
				stk_wdata = f_q;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			load_cnt_q  <= '0;
			n_q         <= '0;
			sp_q        <= '0;
			post_cnt_q  <= '0;
			i_q         <= '0;
			o_q         <= '0;
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
			err_q       <= 1'b0;
		end else begin
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
			err_q       <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					if (xfer) begin
						if (item.last_in) begin
							// close the set: root frame covers all positions
							n_q        <= n_new;
							load_cnt_q <= '0;
							sp_q       <= CW'(1);
							post_cnt_q <= '0;
							state_q    <= ST_POP;
						end else begin
							load_cnt_q <= n_new;
						end
					end
				end
				ST_POP: begin
					if (sp_q == '0) begin
						o_q     <= '0;
						state_q <= ST_OUT;
					end else begin
						sp_q    <= sp_q - CW'(1);
						state_q <= ST_FRAME;
					end
				end
				ST_FRAME: begin
					// stack data valid; preorder read of its root issued now
					state_q <= ST_SYM;
				end
				ST_SYM: begin
					if (f_q.emit) begin
						post_cnt_q <= post_cnt_q + CW'(1);
						state_q    <= ST_POP;
					end else begin
						i_q     <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (hit) begin
						sp_q    <= sp_q + CW'(1);
						state_q <= ST_PUSH_R;
					end else if (scan_end) begin
						// root missing from its range: drop the set
						err_q   <= 1'b1;
						state_q <= ST_LOAD;
					end else begin
						i_q <= i_next;
					end
				end
				ST_PUSH_R: begin
					if (r_len != '0) begin
						sp_q <= sp_q + CW'(1);
					end
					state_q <= ST_PUSH_L;
				end
				ST_PUSH_L: begin
					if (i_q != '0) begin
						sp_q <= sp_q + CW'(1);
					end
					state_q <= ST_POP;
				end
				ST_OUT: begin
					rd_valid_s1 <= 1'b1;
					rd_last_s1  <= (o_q + CW'(1) == n_q);
					o_q         <= o_q + CW'(1);
					if (o_q + CW'(1) == n_q) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// frame and root symbol latches (payload, no reset)
	always_ff @(posedge clk) begin
		if (state_q == ST_FRAME) begin
			f_q <= stk_rdata;
		end
		if (state_q == ST_SYM) begin
			root_q <= pre_rdata;
		end
	end

	// ------------------------------------------------------------------
	// Result port: postorder stream or the single error result
	// ------------------------------------------------------------------
	assign strobe = rd_valid_s1 || err_q;

	always_comb begin
		if (err_q) begin
			result = '{post_symbol: 8'd0, last_out: 1'b1, bad_input: 1'b1};
		end else begin
			result = '{post_symbol: post_rdata, last_out: rd_last_s1, bad_input: 1'b0};
		end
	end

`ifndef SYNTH
	// every stacked frame covers at least one distinct node
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= n_q)
		else $error("frame stack deeper than the tree");

	a_one_source: assert property (@(posedge clk) disable iff (!arst_n)
		!(err_q && rd_valid_s1))
		else $error("error result collides with postorder stream");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (i_q < f_q.len))
		else $error("inorder scan ran past its range");

	a_post_fill: assert property (@(posedge clk) disable iff (!arst_n)
		post_we |-> (post_cnt_q < n_q))
		else $error("more postorder symbols than nodes");

	a_out_count: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_POP) && (sp_q == '0)) |-> (post_cnt_q == n_q))
		else $error("rebuild ended with a symbol count other than the node count");
`endif

endmodule

`default_nettype wire
